@@ src/xsr_pkg.sv @@
// Shared constants, types and the xorshift scramble for the ranged generator.
package xsr_pkg;

   localparam int WORD_W  = 64;
   localparam int HALF_W  = WORD_W / 2;
   localparam int COUNT_W = $clog2(WORD_W);

   localparam logic [WORD_W-1:0] MULTIPLIER  = 64'd2685821657736338717;
   localparam logic [WORD_W-1:0] ALL_ONES    = {WORD_W{1'b1}};
   localparam logic [WORD_W-1:0] STATE_RESET = 64'd1;

   localparam int SHIFT_A = 12;
   localparam int SHIFT_B = 25;
   localparam int SHIFT_C = 27;

   // request into the iterative divider
   typedef struct packed {
      logic              start;
      logic [WORD_W-1:0] dividend;
      logic [WORD_W-1:0] divisor;
   } div_req_type;

   // answer from the iterative divider; remainder holds while done is set
   typedef struct packed {
      logic              done;
      logic [WORD_W-1:0] remainder;
   } div_rsp_type;

   function automatic logic [WORD_W-1:0] scramble(input logic [WORD_W-1:0] value);
      logic [WORD_W-1:0] v;
      v = value;
      v = v ^ (v >> SHIFT_A);
      v = v ^ (v << SHIFT_B);
      v = v ^ (v >> SHIFT_C);
      return v;
   endfunction

endpackage

@@ src/xorshift64_star_ranged_rng_top.sv @@
// Top level of the ranged xorshift64* generator: sequencer, shared multiplier, output register.
//
//   channel   direction  handshake            payload
//   req       in         req_valid/req_stall  req_upper_bound[63:0], req_seed_mode
//   rsp       out        rsp_valid/rsp_stall  rsp_random_value[63:0]
//
// At acceptance the start value is scrambled into the generator state; the product is then
// built in states MUL0 to MUL3 on one shared 32x32 multiplier, the bit-serial divider forms
// the remainder, and the output register loads it; only then is the next item taken.
// Reset is synchronous and sets the generator state to one.
// req_stall is high while an item is in work; a waiting result does not block the
// next item, and the divider holds its remainder until the output register frees.
module xorshift64_star_ranged_rng_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_upper_bound,
   input  logic        req_seed_mode,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_random_value
);

   localparam int W = xsr_pkg::WORD_W;
   localparam int H = xsr_pkg::HALF_W;

   // sequencer codes
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL0 = 3'd1;  // low x low
   localparam logic [2:0] ST_MUL1 = 3'd2;  // high x low, take first product
   localparam logic [2:0] ST_MUL2 = 3'd3;  // low x high, add cross term
   localparam logic [2:0] ST_MUL3 = 3'd4;  // add last cross term, start divider
   localparam logic [2:0] ST_DIV  = 3'd5;  // wait for remainder and output slot

   logic [2:0]   seq_ff, seq_in;
   logic [W-1:0] gen_state_ff, gen_state_in;
   logic [W-1:0] modulus_ff, modulus_in;
   logic [W-1:0] prod_ff, prod_in;
   logic [W-1:0] acc_ff, acc_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [W-1:0] rsp_value_ff, rsp_value_in;

   logic         req_take;
   logic         rsp_take;
   logic         out_free;
   logic         rsp_load;
   logic [W-1:0] start_value;
   logic [W-1:0] bound_plus;
   logic [H-1:0] mul_a, mul_b;

   xsr_pkg::div_req_type div_req;
   xsr_pkg::div_rsp_type div_rsp;

   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid_ff && !rsp_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_load = (seq_ff == ST_DIV) && div_rsp.done && out_free;

   // start from the bound when seeding, else from the stored state plus one
   assign start_value = req_seed_mode ? req_upper_bound : gen_state_ff + 1'b1;
   // bound plus one; an all-ones bound wraps to zero and uses 2^64-1 instead
   assign bound_plus  = req_upper_bound + 1'b1;

   // operand select for the single shared 32x32 multiplier
   always_comb begin
      case (seq_ff)
         ST_MUL0: begin
            mul_a = gen_state_ff[H-1:0];
            mul_b = xsr_pkg::MULTIPLIER[H-1:0];
         end
         ST_MUL1: begin
            mul_a = gen_state_ff[W-1:H];
            mul_b = xsr_pkg::MULTIPLIER[H-1:0];
         end
         default: begin
            mul_a = gen_state_ff[H-1:0];
            mul_b = xsr_pkg::MULTIPLIER[W-1:H];
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   always_comb begin
      seq_in       = seq_ff;
      gen_state_in = gen_state_ff;
      modulus_in   = modulus_ff;
      acc_in       = acc_ff;
      div_req.start    = 1'b0;
      div_req.divisor  = modulus_ff;
      case (seq_ff)
         ST_IDLE: begin
            if (req_take) begin
               gen_state_in = xsr_pkg::scramble(start_value);
               modulus_in   = (bound_plus == '0) ? xsr_pkg::ALL_ONES : bound_plus;
               seq_in       = ST_MUL0;
            end
         end
         ST_MUL0: begin
            seq_in = ST_MUL1;
         end
         ST_MUL1: begin
            acc_in = prod_ff;
            seq_in = ST_MUL2;
         end
         ST_MUL2: begin
            // cross terms only reach the upper half modulo 2^64
            acc_in = {acc_ff[W-1:H] + prod_ff[H-1:0], acc_ff[H-1:0]};
            seq_in = ST_MUL3;
         end
         ST_MUL3: begin
            acc_in        = {acc_ff[W-1:H] + prod_ff[H-1:0], acc_ff[H-1:0]};
            div_req.start = 1'b1;
            seq_in        = ST_DIV;
         end
         ST_DIV: begin
            if (rsp_load) begin
               seq_in = ST_IDLE;
            end
         end
         default: begin
            seq_in = ST_IDLE;
         end
      endcase
      div_req.dividend = acc_in;
   end

   xsr_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // output register: load a finished remainder, drop the flag once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = div_rsp.remainder;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= ST_IDLE;
         gen_state_ff <= xsr_pkg::STATE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         seq_ff       <= seq_in;
         gen_state_ff <= gen_state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      modulus_ff   <= modulus_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign req_stall        = (seq_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_random_value = rsp_value_ff;

endmodule

@@ src/xsr_div.sv @@
// Radix-2 restoring divider that keeps only the remainder, one bit per cycle.
module xsr_div (
   input  logic                clock,
   input  logic                reset,
   input  xsr_pkg::div_req_type div_req,
   output xsr_pkg::div_rsp_type div_rsp
);

   logic [xsr_pkg::WORD_W-1:0]  rem_ff, rem_in;
   logic [xsr_pkg::WORD_W-1:0]  dvd_ff, dvd_in;
   logic [xsr_pkg::WORD_W-1:0]  dsr_ff, dsr_in;
   logic [xsr_pkg::COUNT_W-1:0] count_ff, count_in;
   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;

   logic [xsr_pkg::WORD_W:0]    trial;
   logic [xsr_pkg::WORD_W:0]    diff;

   // shift in the next dividend bit, subtract the divisor when it fits
   assign trial = {rem_ff, dvd_ff[xsr_pkg::WORD_W-1]};
   assign diff  = trial - {1'b0, dsr_ff};

   always_comb begin
      rem_in   = rem_ff;
      dvd_in   = dvd_ff;
      dsr_in   = dsr_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = done_ff;
      if (div_req.start) begin
         rem_in   = '0;
         dvd_in   = div_req.dividend;
         dsr_in   = div_req.divisor;
         count_in = '0;
         busy_in  = 1'b1;
         done_in  = 1'b0;
      end else if (busy_ff) begin
         rem_in   = diff[xsr_pkg::WORD_W] ? trial[xsr_pkg::WORD_W-1:0]
                                          : diff[xsr_pkg::WORD_W-1:0];
         dvd_in   = {dvd_ff[xsr_pkg::WORD_W-2:0], 1'b0};
         count_in = count_ff + 1'b1;
         if (count_ff == {xsr_pkg::COUNT_W{1'b1}}) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
   end

   assign div_rsp = {done_ff, rem_ff};

endmodule

@@ src/xorshift64_star_ranged_rng_chk.sv @@
// Port-level checker for the ranged generator and its bind to the top level.
module xorshift64_star_ranged_rng_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [63:0] rsp_random_value
);

   // reset leaves the block ready with no result pending
   a_reset_clean: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("block not idle after reset");

   // an accepted item closes the input side while it is in work
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input not stalled after an item was taken");

   // no result appears in the cycle right after an item is taken
   a_no_instant_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> !$rose(rsp_valid))
      else $error("result appeared too early");

   // a stalled result holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_random_value)))
      else $error("stalled result changed");

endmodule

bind xorshift64_star_ranged_rng_top xorshift64_star_ranged_rng_chk u_chk (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_random_value (rsp_random_value)
);

@@ verif/tb_top.sv @@
// Self-checking testbench for the ranged xorshift64* generator.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WORD_W = xsr_pkg::WORD_W;

   typedef logic [WORD_W-1:0] word_type;

   // Request item as queued for the driver
   typedef struct {
      word_type upper_bound;
      logic     seed_mode;
   } bound_request_type;

   localparam logic  ADVANCE_STATE   = 1'b0;
   localparam logic  SEED_FROM_BOUND = 1'b1;

   localparam word_type GOLDEN_MULT     = 64'd2685821657736338717;
   localparam word_type FULL_WORD       = {WORD_W{1'b1}};
   localparam word_type STATE_AT_RESET  = 64'd1;
   localparam int    MIX_RIGHT_FIRST = 12;
   localparam int    MIX_LEFT        = 25;
   localparam int    MIX_RIGHT_LAST  = 27;

   localparam int    RESET_CYCLES    = 7;
   localparam int    HOLD_CYCLES     = 400;
   localparam int    DRAIN_CYCLES    = 100;
   localparam int    ITEMS_PER_PHASE = 175;
   localparam longint LIMIT_NS       = 1_000_000;

   logic     clock           = 1'b0;
   logic     reset           = 1'b1;
   logic     req_valid       = 1'b0;
   logic     req_stall;
   word_type req_upper_bound = '0;
   logic     req_seed_mode   = 1'b0;
   logic     rsp_valid;
   logic     rsp_stall       = 1'b0;
   word_type rsp_random_value;

   // Item queues and predictor state
   bound_request_type bound_requests[$];
   word_type          predicted_values[$];
   word_type          gen_state = STATE_AT_RESET;
   bound_request_type next_req;
   word_type          expected_value;

   // Idling controls, changed only between phases
   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;

   // Long receiver hold-off
   logic        hold_request = 1'b0;
   logic        hold_served  = 1'b0;
   logic        hold_off     = 1'b0;
   int unsigned hold_left    = 0;

   // Run statistics
   int unsigned mismatches     = 0;
   int unsigned items_accepted = 0;
   int unsigned results_seen   = 0;
   int unsigned reseeds_taken  = 0;
   int unsigned zero_bounds    = 0;
   int unsigned full_bounds    = 0;

   xorshift64_star_ranged_rng_top DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_upper_bound  (req_upper_bound),
      .req_seed_mode    (req_seed_mode),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_random_value (rsp_random_value)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Forward xorshift: right, left, right
   function automatic word_type xorshift_mix(input word_type value);
      word_type v;
      v = value;
      v = v ^ (v >> MIX_RIGHT_FIRST);
      v = v ^ (v << MIX_LEFT);
      v = v ^ (v >> MIX_RIGHT_LAST);
      return v;
   endfunction

   // Inverse of the xorshift; used to build a seed that lands the state on all ones
   function automatic word_type xorshift_unmix(input word_type value);
      word_type y;
      word_type x;
      y = value;
      x = y;
      for (int i = 0; i < 6; i++) x = y ^ (x >> MIX_RIGHT_LAST);
      y = x;
      for (int i = 0; i < 6; i++) x = y ^ (x << MIX_LEFT);
      y = x;
      for (int i = 0; i < 6; i++) x = y ^ (x >> MIX_RIGHT_FIRST);
      return x;
   endfunction

   // Advance the predicted generator state and return the ranged value
   function automatic word_type next_random_value(input word_type bound, input logic seed);
      word_type start;
      word_type product;
      word_type modulus;
      start     = (seed == SEED_FROM_BOUND) ? bound : gen_state + 64'd1;
      gen_state = xorshift_mix(start);
      product   = gen_state * GOLDEN_MULT;
      modulus   = bound + 64'd1;
      // all-ones bound wraps the modulus to zero; use 2^64-1 instead
      if (modulus == '0) modulus = FULL_WORD;
      return product % modulus;
   endfunction

   task automatic report_mismatch(input string what, input word_type got,
                                  input word_type want);
      mismatches++;
      $display("tb_top: MISMATCH at %0t: %s: got %h, expected %h", $realtime, what, got, want);
   endtask

   function automatic word_type random_word();
      return {$urandom, $urandom};
   endfunction

   task automatic push_request(input word_type bound, input logic seed);
      bound_request_type r;
      r.upper_bound = bound;
      r.seed_mode   = seed;
      bound_requests.push_back(r);
   endtask

   // Mostly plain advances over bounds of every magnitude, with reseeds and edge bounds
   task automatic push_random_request();
      int unsigned pick;
      word_type    bound;
      logic        seed;
      pick  = $urandom_range(99);
      bound = random_word() >> $urandom_range(WORD_W - 1);
      seed  = ADVANCE_STATE;
      if (pick < 12) begin
         seed = SEED_FROM_BOUND;
         if (pick < 9) bound = random_word();
      end else if (pick < 16) begin
         bound = '0;
      end else if (pick < 20) begin
         bound = FULL_WORD;
      end else if (pick < 24) begin
         bound = FULL_WORD - word_type'($urandom_range(3));
      end else if (pick < 30) begin
         bound = word_type'($urandom_range(15));
      end
      push_request(bound, seed);
   endtask

   task automatic wait_drained();
      while (bound_requests.size() != 0 || req_valid || predicted_values.size() != 0)
         @(negedge clock);
   endtask

   task automatic run_phase(input int unsigned send_pct, input int unsigned recv_pct,
                            input logic with_hold);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      if (with_hold) hold_request <= 1'b1;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) push_random_request();
      wait_drained();
   endtask

   // Driver: hold the item while stalled, advance the predictor on acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gen_state = STATE_AT_RESET;
      end else begin
         if (req_valid && !req_stall) begin
            predicted_values.push_back(next_random_value(req_upper_bound, req_seed_mode));
            items_accepted++;
            if (req_seed_mode == SEED_FROM_BOUND) reseeds_taken++;
            if (req_upper_bound == '0) zero_bounds++;
            if (req_upper_bound == FULL_WORD) full_bounds++;
         end
         if (!req_valid || !req_stall) begin
            if (bound_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_req = bound_requests.pop_front();
               req_valid       <= 1'b1;
               req_upper_bound <= next_req.upper_bound;
               req_seed_mode   <= next_req.seed_mode;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each accepted result with the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (predicted_values.size() == 0) begin
               report_mismatch("result with no request outstanding", rsp_random_value, '0);
            end else begin
               expected_value = predicted_values.pop_front();
               if (rsp_random_value !== expected_value)
                  report_mismatch("random_value", rsp_random_value, expected_value);
            end
         end
         rsp_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
      end
   end

   // Hold-off counter: stall the result side for a long stretch, once
   always @(posedge clock) begin
      if (reset) begin
         hold_off    <= 1'b0;
         hold_left   <= 0;
         hold_served <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         hold_off  <= (hold_left != 1);
      end else if (hold_request && !hold_served) begin
         hold_off    <= 1'b1;
         hold_left   <= HOLD_CYCLES;
         hold_served <= 1'b1;
      end
   end

   initial begin
      #(LIMIT_NS * 1ns);
      $display("tb_top: timeout with %0d predictions outstanding", predicted_values.size());
      $display("tb_top: done, errors");
      $finish;
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: edge bounds, zero seed, state wrap, alternating bit patterns
      push_request('0, ADVANCE_STATE);
      push_request(FULL_WORD, ADVANCE_STATE);
      push_request(64'd1, ADVANCE_STATE);
      push_request('0, SEED_FROM_BOUND);                 // zero seed: state becomes zero
      push_request(64'd1000, ADVANCE_STATE);             // restarts from one
      push_request(FULL_WORD, SEED_FROM_BOUND);
      push_request(FULL_WORD - 64'd1, ADVANCE_STATE);
      push_request(64'h8000_0000_0000_0000, ADVANCE_STATE);
      push_request(64'h7FFF_FFFF_FFFF_FFFF, ADVANCE_STATE);
      push_request(64'h0000_0000_FFFF_FFFF, ADVANCE_STATE);
      push_request(64'h0000_0001_0000_0000, ADVANCE_STATE);
      push_request(xorshift_unmix(FULL_WORD), SEED_FROM_BOUND);  // state becomes all ones
      push_request(64'd12345, ADVANCE_STATE);             // state + 1 wraps to zero
      push_request(64'd12345, ADVANCE_STATE);
      push_request(64'd1, SEED_FROM_BOUND);
      push_request(64'hAAAA_AAAA_AAAA_AAAA, SEED_FROM_BOUND);
      push_request(64'h5555_5555_5555_5555, ADVANCE_STATE);
      push_request(xorshift_unmix(FULL_WORD), SEED_FROM_BOUND);
      push_request(FULL_WORD, ADVANCE_STATE);            // all-ones bound on a wrapped start
      push_request(64'd2, ADVANCE_STATE);
      wait_drained();

      // Random phases: no idling with one long hold-off, sender idle, receiver stall, both
      run_phase(0, 0, 1'b1);
      run_phase(56, 0, 1'b0);
      run_phase(0, 56, 1'b0);
      run_phase(8, 8, 1'b0);

      send_idle_pct  = 0;
      recv_stall_pct = 0;
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("tb_top: %0d requests (%0d reseeds, %0d zero bounds, %0d all-ones bounds)",
               items_accepted, reseeds_taken, zero_bounds, full_bounds);
      $display("tb_top: %0d results checked over four idle mixes and a %0d-cycle hold-off",
               results_seen, HOLD_CYCLES);
      if (mismatches == 0 && predicted_values.size() == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule
